// ===== hw/rtl/tsdf_block_touch_dedup_macros.svh =====
// ---------------------------------------------------------------------------
// Block touch dedup assertion macros
// Shared assertion helpers for the block touch dedup RTL.
// ---------------------------------------------------------------------------
`ifndef TSDF_BLOCK_TOUCH_DEDUP_MACROS_SVH
`define TSDF_BLOCK_TOUCH_DEDUP_MACROS_SVH
`ifndef SYNTHESIS
`define TBD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TBD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TBD_ASSERT(lbl, clk, rstn, prop, msg)
`define TBD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/tbd_pkg.sv =====
// ---------------------------------------------------------------------------
// Block touch dedup package
// Shared constants, types and the hash primes.
// ---------------------------------------------------------------------------
package tbd_pkg;
  localparam int unsigned TableEntries   = 4096;
  localparam int unsigned MaxSpan        = 4;
  localparam int unsigned BlockCoordBits = 21;
  localparam int unsigned OutBits        = 21;
  localparam int unsigned KeyBits        = 64;

  localparam logic [31:0] HashP0 = 32'd73856093;
  localparam logic [31:0] HashP1 = 32'd19349669;
  localparam logic [31:0] HashP2 = 32'd83492791;

  localparam logic [1:0] RegVoxel = 2'd0;
  localparam logic [1:0] RegRes   = 2'd1;
  localparam logic [1:0] RegTrunc = 2'd2;

  typedef enum logic [3:0] {
    StIdle, StClear, StDivStart, StDiv, StRange, StHashA, StHashB, StRead,
    StCheck, StNext
  } state_e;

  typedef struct packed {
    logic start;
    logic sign;
  } div_ctrl_t;
endpackage

// ===== hw/rtl/tbd_ram.sv =====
// ---------------------------------------------------------------------------
// Block touch dedup RAM
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module tbd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hw/rtl/tbd_div.sv =====
// ---------------------------------------------------------------------------
// Block touch dedup divider
// Restoring floor divider of a 34 bit signed dividend by a 31 bit divisor,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tbd_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbd_pkg::div_ctrl_t  ctrl_i,
  input  logic [32:0]         mag_i,
  input  logic [30:0]         den_i,
  output logic                done_o,
  output logic signed [34:0]  quot_o
);
  logic [32:0] q_q, q_d;
  logic [31:0] r_q, r_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [31:0] trial;
  logic [32:0] sub;
  logic [34:0] qext;

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    busy_d = busy_q;
    trial = {r_q[30:0], q_q[32]};
    sub = {1'b0, trial} - {2'b0, den_i};
    if (ctrl_i.start) begin
      q_d = mag_i;
      r_d = '0;
      cnt_d = 6'd33;
      neg_d = ctrl_i.sign;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!sub[32]) begin
        r_d = sub[31:0];
        q_d = {q_q[31:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    neg_q <= neg_d;
  end

  assign done_o = !busy_q;
  assign qext = {2'b00, q_q};
  always_comb begin
    if (neg_q) begin
      quot_o = (r_q != '0) ? $signed(~qext) : $signed(-qext);
    end else begin
      quot_o = $signed(qext);
    end
  end
endmodule

// ===== hw/rtl/tsdf_block_touch_dedup.sv =====
// ---------------------------------------------------------------------------
// Block touch dedup top level
// Finds the voxel blocks around a point and reports those not yet seen.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake
// cmd       in         start_i, busy_o
// result    out        valid_o, one cycle each
// config    in         APB psel/penable/pwrite, pready tied high
// After reset the table is swept clear, busy high.
// A point runs six serial divisions and a range step, then walks its blocks
// through hash, read and check, with a read and check per further probed slot.
// A new frame adds a clear sweep of all table entries before the divisions.
// The final result of a point leaves via the done, flush and output registers.
// The table memory port sets the probe rate. The receiver cannot stall.
module tsdf_block_touch_dedup #(
  parameter int unsigned TableEntries   = tbd_pkg::TableEntries,
  parameter int unsigned MaxSpan        = tbd_pkg::MaxSpan,
  parameter int unsigned BlockCoordBits = tbd_pkg::BlockCoordBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic                new_frame_i,
  output logic                valid_o,
  output logic signed [20:0]  block_x_o,
  output logic signed [20:0]  block_y_o,
  output logic signed [20:0]  block_z_o,
  output logic                last_o,
  output logic                clipped_o,
  output logic                not_recorded_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
`include "tsdf_block_touch_dedup_macros.svh"
  localparam int unsigned AW = $clog2(TableEntries);
  localparam int unsigned CW = $clog2(TableEntries + 1);
  localparam logic signed [34:0] SatHi = 35'sd2 ** (BlockCoordBits - 1) - 35'sd1;
  localparam logic signed [34:0] SatLo = -(35'sd2 ** (BlockCoordBits - 1));
  localparam logic [2:0] SpanM1 = 3'(MaxSpan - 1);

  logic [23:0] vox_q, trunc_q;
  logic [6:0]  res_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vox_q <= 24'd393;
      res_q <= 7'd16;
      trunc_q <= 24'd2621;
    end else if (wr_en) begin
      unique case (reg_idx)
        tbd_pkg::RegVoxel: vox_q <= pwdata[23:0];
        tbd_pkg::RegRes:   res_q <= pwdata[6:0];
        tbd_pkg::RegTrunc: trunc_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tbd_pkg::RegVoxel: prdata = {8'd0, vox_q};
      tbd_pkg::RegRes:   prdata = {25'd0, res_q};
      tbd_pkg::RegTrunc: prdata = {8'd0, trunc_q};
      default:           prdata = '0;
    endcase
  end

  tbd_pkg::state_e st_q, st_d;
  logic signed [31:0] px_q, py_q, pz_q;
  logic               nf_q;
  logic [30:0]        bs_q;
  logic [2:0]         dn_q, dn_d;
  logic signed [34:0] qv_q [6];
  logic signed [20:0] lo_q [3];
  logic [2:0]         sp_q [3];
  logic [2:0]         ix_q, iy_q, iz_q;
  logic               clip_q;
  logic [AW-1:0]      addr_q;
  logic [CW-1:0]      cnt_q, sweep_q;
  logic [63:0]        key_q;
  logic [AW-1:0]      hx_q, hy_q, hz_q;
  logic [AW-1:0]      hash_d;
  logic               out_v_q, out_nr_q;
  logic signed [20:0] ox_q, oy_q, oz_q;
  logic [CW-1:0]      probes_q;

  tbd_pkg::div_ctrl_t dctl;
  logic [32:0] dmag;
  logic signed [33:0] dnum;
  logic        ddone;
  logic signed [34:0] dq;
  logic signed [31:0] pcur;

  always_comb begin
    unique case (dn_q[2:1])
      2'd0:    pcur = px_q;
      2'd1:    pcur = py_q;
      default: pcur = pz_q;
    endcase
    dnum = dn_q[0] ? (34'(pcur) + 34'($signed({1'b0, trunc_q})))
                   : (34'(pcur) - 34'($signed({1'b0, trunc_q})));
    dmag = dnum[33] ? 33'(-dnum) : dnum[32:0];
    dctl.sign = dnum[33];
    dctl.start = (st_q == tbd_pkg::StDivStart);
  end

  tbd_div u_div (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (dctl), .mag_i (dmag),
    .den_i (bs_q), .done_o (ddone), .quot_o (dq)
  );

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_wd, ram_rd;

  tbd_ram #(.Width(64), .Depth(TableEntries)) u_ram (
    .clk_i (clk_i), .we_i (ram_we), .addr_i (ram_addr),
    .wdata_i (ram_wd), .rdata_o (ram_rd)
  );

  logic signed [20:0] cx, cy, cz;
  logic full, hit, empty, last_blk, resolved;
  assign cx = lo_q[0] + 21'(ix_q);
  assign cy = lo_q[1] + 21'(iy_q);
  assign cz = lo_q[2] + 21'(iz_q);
  assign full = (probes_q == CW'(TableEntries));
  assign empty = !ram_rd[63];
  assign hit = (ram_rd == key_q);
  assign resolved = full || hit || empty;
  assign last_blk = (ix_q == sp_q[0]) && (iy_q == sp_q[1]) && (iz_q == sp_q[2]);
  assign hash_d = (hx_q * tbd_pkg::HashP0[AW-1:0])
                ^ (hy_q * tbd_pkg::HashP1[AW-1:0])
                ^ (hz_q * tbd_pkg::HashP2[AW-1:0]);

  logic signed [34:0] lo_s [3], hi_s [3];
  logic               rclip;
  always_comb begin
    rclip = 1'b0;
    for (int a = 0; a < 3; a++) begin
      lo_s[a] = qv_q[2*a];
      hi_s[a] = qv_q[2*a+1];
      if (lo_s[a] > SatHi) begin lo_s[a] = SatHi; rclip = 1'b1; end
      if (lo_s[a] < SatLo) begin lo_s[a] = SatLo; rclip = 1'b1; end
      if (hi_s[a] > SatHi) begin hi_s[a] = SatHi; rclip = 1'b1; end
      if (hi_s[a] < SatLo) begin hi_s[a] = SatLo; rclip = 1'b1; end
      if (hi_s[a] - lo_s[a] > 35'(SpanM1)) begin
        hi_s[a] = lo_s[a] + 35'(SpanM1);
        rclip = 1'b1;
      end
    end
  end

  logic busy_int;
  always_comb begin
    st_d = st_q;
    dn_d = dn_q;
    ram_we = 1'b0;
    ram_addr = addr_q;
    ram_wd = key_q;
    busy_int = (st_q != tbd_pkg::StIdle);
    unique case (st_q)
      tbd_pkg::StIdle: begin
        if (start_i) begin
          st_d = new_frame_i ? tbd_pkg::StClear : tbd_pkg::StDivStart;
          dn_d = '0;
        end
      end
      tbd_pkg::StClear: begin
        ram_we = 1'b1;
        ram_addr = sweep_q[AW-1:0];
        ram_wd = '0;
        if (sweep_q == CW'(TableEntries - 1)) begin
          st_d = nf_q ? tbd_pkg::StDivStart : tbd_pkg::StIdle;
        end
      end
      tbd_pkg::StDivStart: st_d = tbd_pkg::StDiv;
      tbd_pkg::StDiv: begin
        if (ddone) begin
          dn_d = dn_q + 3'd1;
          st_d = (dn_q == 3'd5) ? tbd_pkg::StRange : tbd_pkg::StDivStart;
        end
      end
      tbd_pkg::StRange: st_d = tbd_pkg::StHashA;
      tbd_pkg::StHashA: st_d = tbd_pkg::StHashB;
      tbd_pkg::StHashB: st_d = tbd_pkg::StRead;
      tbd_pkg::StRead: st_d = tbd_pkg::StCheck;
      tbd_pkg::StCheck: begin
        if (resolved) begin
          if (empty && !full) begin
            ram_we = 1'b1;
          end
          st_d = last_blk ? tbd_pkg::StIdle : tbd_pkg::StNext;
        end else begin
          st_d = tbd_pkg::StRead;
        end
      end
      tbd_pkg::StNext: st_d = tbd_pkg::StHashA;
      default: st_d = tbd_pkg::StIdle;
    endcase
  end
  assign busy_o = busy_int;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= tbd_pkg::StClear;
      nf_q <= 1'b0;
      sweep_q <= '0;
      cnt_q <= '0;
      dn_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      dn_q <= dn_d;
      out_v_q <= (st_q == tbd_pkg::StCheck) && resolved && !hit;
      if (st_q == tbd_pkg::StIdle && start_i) begin
        nf_q <= new_frame_i;
        sweep_q <= '0;
      end
      if (st_q == tbd_pkg::StClear) begin
        sweep_q <= sweep_q + CW'(1);
        cnt_q <= '0;
      end
      if (st_q == tbd_pkg::StCheck && resolved && empty && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == tbd_pkg::StIdle && start_i) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      bs_q <= 31'(((vox_q == '0) ? 24'd1 : vox_q)) * 31'(((res_q == '0) ? 7'd1 : res_q));
    end
    if (st_q == tbd_pkg::StDiv && ddone) begin
      qv_q[dn_q] <= dq;
    end
    if (st_q == tbd_pkg::StRange) begin
      clip_q <= rclip;
      for (int a = 0; a < 3; a++) begin
        lo_q[a] <= lo_s[a][20:0];
        sp_q[a] <= 3'(hi_s[a] - lo_s[a]);
      end
      ix_q <= '0;
      iy_q <= '0;
      iz_q <= '0;
    end
    if (st_q == tbd_pkg::StHashA) begin
      hx_q <= cx[AW-1:0];
      hy_q <= cy[AW-1:0];
      hz_q <= cz[AW-1:0];
      key_q <= {1'b1, cz, cy, cx};
    end
    if (st_q == tbd_pkg::StHashB) begin
      addr_q <= hash_d;
      probes_q <= '0;
    end
    if (st_q == tbd_pkg::StCheck && !resolved) begin
      addr_q <= addr_q + AW'(1);
      probes_q <= probes_q + CW'(1);
    end
    if (st_q == tbd_pkg::StCheck) begin
      ox_q <= cx;
      oy_q <= cy;
      oz_q <= cz;
      out_nr_q <= full;
    end
    if (st_q == tbd_pkg::StNext) begin
      if (iz_q != sp_q[2]) begin
        iz_q <= iz_q + 3'd1;
      end else begin
        iz_q <= '0;
        if (iy_q != sp_q[1]) begin
          iy_q <= iy_q + 3'd1;
        end else begin
          iy_q <= '0;
          ix_q <= ix_q + 3'd1;
        end
      end
    end
  end

  // A new block is held until the next new block or the end of the walk is
  // known, so the final new block of a point leaves with the last flag set.
  logic               pend_q, pend_d, done_q, flush_q, emit_v, emit_last;
  logic signed [20:0] hx2_q, hy2_q, hz2_q;
  logic               hnr_q, hclip_q;

  always_comb begin
    pend_d = pend_q;
    emit_v = 1'b0;
    emit_last = 1'b0;
    if (out_v_q) begin
      emit_v = pend_q;
      pend_d = 1'b1;
    end else if (flush_q) begin
      emit_v = pend_q;
      emit_last = 1'b1;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
      flush_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      pend_q <= pend_d;
      done_q <= (st_q == tbd_pkg::StCheck) && resolved && last_blk;
      flush_q <= done_q;
      valid_o <= emit_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q) begin
      hx2_q <= ox_q;
      hy2_q <= oy_q;
      hz2_q <= oz_q;
      hnr_q <= out_nr_q;
      hclip_q <= clip_q;
    end
    if (emit_v) begin
      block_x_o <= hx2_q;
      block_y_o <= hy2_q;
      block_z_o <= hz2_q;
      clipped_o <= hclip_q;
      not_recorded_o <= hnr_q;
      last_o <= emit_last;
    end
  end

  `TBD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(TableEntries), "count overflow")
  `TBD_ASSERT_NEVER(a_idle_valid, clk_i, rst_ni, out_v_q && st_q == tbd_pkg::StClear, "result during clear")
  `TBD_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "start not taken")
endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// Block touch dedup testbench
// Sends points to the block, predicts the newly touched blocks of each point
// with its own copy of the seen set and checks every result transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  typedef struct packed {
    logic [20:0] bx;
    logic [20:0] by;
    logic [20:0] bz;
    logic        last;
    logic        clip;
    logic        nrec;
  } touch_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic               new_frame_i = 1'b0;
  logic               valid_o;
  logic signed [20:0] block_x_o;
  logic signed [20:0] block_y_o;
  logic signed [20:0] block_z_o;
  logic               last_o;
  logic               clipped_o;
  logic               not_recorded_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  tsdf_block_touch_dedup dut (.*);

  touch_t      touch_q[$];
  logic [63:0] seen_tbl[tbd_pkg::TableEntries];
  int unsigned seen_cnt;
  logic [23:0] cfg_voxel;
  logic [6:0]  cfg_res;
  logic [23:0] cfg_trunc;
  int          errors = 0;
  int          last_x = 0;
  int          last_y = 0;
  int          last_z = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint floor_q(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint sat_block(longint v, inout bit clip);
    longint top;
    top = (longint'(1) <<< (tbd_pkg::BlockCoordBits - 1)) - 1;
    if (v > top) begin
      clip = 1'b1;
      return top;
    end
    if (v < -top - 1) begin
      clip = 1'b1;
      return -top - 1;
    end
    return v;
  endfunction

  task automatic block_span(input longint p, input longint tr, input longint bs,
                            output longint l, output longint h, inout bit clip);
    l = sat_block(floor_q(p - tr, bs), clip);
    h = sat_block(floor_q(p + tr, bs), clip);
    if (h - l + 1 > tbd_pkg::MaxSpan) begin
      h = l + tbd_pkg::MaxSpan - 1;
      clip = 1'b1;
    end
  endtask

  // Returns 1 if already seen, 0 if newly stored, 2 if new with the table full.
  function automatic int lookup_store(longint x, longint y, longint z);
    logic [63:0]     key;
    longint unsigned h;
    int unsigned     idx;
    key = {1'b1, z[20:0], y[20:0], x[20:0]};
    h = (longint'(x) * longint'(tbd_pkg::HashP0)) ^ (longint'(y) * longint'(tbd_pkg::HashP1))
      ^ (longint'(z) * longint'(tbd_pkg::HashP2));
    idx = h % tbd_pkg::TableEntries;
    for (int i = 0; i < tbd_pkg::TableEntries; i++) begin
      if (!seen_tbl[idx][63]) begin
        seen_tbl[idx] = key;
        seen_cnt++;
        return 0;
      end
      if (seen_tbl[idx] == key) return 1;
      idx = (idx + 1) % tbd_pkg::TableEntries;
    end
    return 2;
  endfunction

  task automatic predict_touches(input logic signed [31:0] px, py, pz, input logic nf);
    longint bs, tr, xl, xh, yl, yh, zl, zh;
    bit     clip;
    int     r;
    touch_t t;
    touch_t pend[$];
    clip = 1'b0;
    bs = longint'(cfg_voxel == 0 ? 24'd1 : cfg_voxel) * longint'(cfg_res == 0 ? 7'd1 : cfg_res);
    tr = longint'(cfg_trunc);
    if (nf) begin
      foreach (seen_tbl[i]) seen_tbl[i] = '0;
      seen_cnt = 0;
    end
    block_span(longint'(px), tr, bs, xl, xh, clip);
    block_span(longint'(py), tr, bs, yl, yh, clip);
    block_span(longint'(pz), tr, bs, zl, zh, clip);
    for (longint x = xl; x <= xh; x++)
      for (longint y = yl; y <= yh; y++)
        for (longint z = zl; z <= zh; z++) begin
          r = lookup_store(x, y, z);
          if (r != 1) begin
            t.bx = x[20:0];
            t.by = y[20:0];
            t.bz = z[20:0];
            t.last = 1'b0;
            t.clip = clip;
            t.nrec = (r == 2);
            pend.push_back(t);
          end
        end
    if (pend.size() > 0) pend[pend.size() - 1].last = 1'b1;
    foreach (pend[i]) touch_q.push_back(pend[i]);
  endtask

  task automatic send_point(input logic signed [31:0] px, py, pz, input logic nf);
    int gap;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) gap = 0;
    else if (sel < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    new_frame_i <= nf;
    do @(posedge clk_i); while (busy_o);
    predict_touches(px, py, pz, nf);
    last_x = px;
    last_y = py;
    last_z = pz;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (touch_q.size() > 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      tbd_pkg::RegVoxel: cfg_voxel = value[23:0];
      tbd_pkg::RegRes:   cfg_res = value[6:0];
      default:           cfg_trunc = value[23:0];
    endcase
  endtask

  task automatic set_config(input logic [23:0] vs, input logic [6:0] rs, input logic [23:0] tr);
    wait_idle();
    write_reg(tbd_pkg::RegVoxel, {8'($urandom_range(0, 255)), vs});
    write_reg(tbd_pkg::RegRes, {25'($urandom), rs});
    write_reg(tbd_pkg::RegTrunc, {8'($urandom_range(0, 255)), tr});
  endtask

  task automatic test_directed();
    send_point(32'sd0, 32'sd0, 32'sd0, 1'b1);
    send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_point(32'hffffffff, 32'sd1, -32'sd6288, 1'b0);
    send_point(32'sd6288, 32'sd6287, 32'sd12576, 1'b1);
    send_point(32'sd6288, 32'sd6287, 32'sd12576, 1'b0);
    set_config(24'd0, 7'd0, 24'd0);
    send_point(32'sd5, -32'sd5, 32'sd0, 1'b0);
    set_config(24'd1, 7'd1, 24'hffffff);
    send_point(32'sd100, 32'sd200, 32'sd300, 1'b1);
    send_point(32'sd101, 32'sd200, 32'sd300, 1'b0);
    set_config(24'hffffff, 7'd127, 24'hffffff);
    send_point(32'h7fffffff, 32'sd0, 32'h80000000, 1'b0);
    send_point(32'sd0, 32'sd0, 32'sd0, 1'b1);
    set_config(24'hffffff, 7'd64, 24'd0);
    send_point(-32'sd1, 32'sd1, 32'h40000000, 1'b0);
    set_config(24'd393, 7'd16, 24'd2621);
  endtask

  task automatic test_table_full();
    set_config(24'd1, 7'd1, 24'd2);
    for (int k = 0; k < tbd_pkg::TableEntries / 64; k++) send_point(4 * k, 0, 0, k == 0);
    set_config(24'd1, 7'd1, 24'd0);
    send_point(32'sd100000, 32'sd7, -32'sd9, 1'b0);
    send_point(32'sd100000, 32'sd7, -32'sd9, 1'b0);
    send_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
    send_point(32'sd0, 32'sd0, 32'sd0, 1'b1);
  endtask

  task automatic test_random();
    longint bs;
    longint px, py, pz;
    int     since_frame;
    int     mode;
    logic   nf;
    since_frame = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(24'd393, 7'd16, 24'd2621);
        1: set_config(24'd1, 7'd1, 24'($urandom_range(0, 8)));
        2: set_config(24'($urandom_range(1, 24'hffffff)), 7'($urandom_range(0, 127)),
                      24'($urandom));
        3: set_config(24'hffffff, 7'd64, 24'hffffff);
        4: set_config(24'($urandom_range(100, 5000)), 7'($urandom_range(1, 64)),
                      24'($urandom_range(0, 30000)));
        default: set_config(24'($urandom), 7'($urandom), 24'($urandom));
      endcase
      bs = longint'(cfg_voxel == 0 ? 24'd1 : cfg_voxel) * longint'(cfg_res == 0 ? 7'd1 : cfg_res);
      for (int n = 0; n < 40; n++) begin
        mode = $urandom_range(0, 99);
        if (mode < 40) begin
          px = longint'($urandom_range(0, 20)) * bs - 10 * bs + $urandom_range(0, 1000);
          py = longint'($urandom_range(0, 20)) * bs - 10 * bs + $urandom_range(0, 1000);
          pz = longint'($urandom_range(0, 20)) * bs - 10 * bs + $urandom_range(0, 1000);
        end else if (mode < 75) begin
          px = last_x + $signed($urandom_range(0, 2 * 65535)) - 65535;
          py = last_y + $signed($urandom_range(0, 2 * 65535)) - 65535;
          pz = last_z + $signed($urandom_range(0, 2 * 65535)) - 65535;
        end else begin
          px = $signed($urandom);
          py = $signed($urandom);
          pz = $signed($urandom);
        end
        nf = ($urandom_range(0, 9) == 0) || (since_frame >= 30);
        since_frame = nf ? 0 : since_frame + 1;
        send_point(px[31:0], py[31:0], pz[31:0], nf);
      end
    end
  endtask

  always @(posedge clk_i) begin
    touch_t got;
    touch_t want;
    if (valid_o) begin
      got = {block_x_o, block_y_o, block_z_o, last_o, clipped_o, not_recorded_o};
      if (touch_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = touch_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected x %0d y %0d z %0d last %b clip %b nrec %b, got x %0d y %0d z %0d last %b clip %b nrec %b",
                     $signed(want.bx), $signed(want.by), $signed(want.bz), want.last,
                     want.clip, want.nrec, block_x_o, block_y_o, block_z_o,
                     last_o, clipped_o, not_recorded_o);
        end
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || valid_o || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 200000) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (seen_tbl[i]) seen_tbl[i] = '0;
    seen_cnt = 0;
    cfg_voxel = 24'd393;
    cfg_res = 7'd16;
    cfg_trunc = 24'd2621;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random();
    wait_idle();
    repeat (500) @(posedge clk_i);
    if (errors == 0 && touch_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
